// ----- sv/linear_scan_register_allocator_macros.svh -----
// Assertion macros shared by the allocator RTL
`ifndef LINEAR_SCAN_REGISTER_ALLOCATOR_MACROS_SVH
`define LINEAR_SCAN_REGISTER_ALLOCATOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define LSRA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset
`define LSRA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/lsra_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_pkg
// Types, constants and the pool membership function of the allocator.
// ----------------------------------------------------------------------------
package lsra_pkg;

    localparam int REGNO_BITS = 5;
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_REGISTER_CLASS = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_POOL_MODE      = 2'd1;

    // Pool modes
    localparam logic [1:0] POOL_FULL  = 2'd0;
    localparam logic [1:0] POOL_EIGHT = 2'd1;

    // Pool boundaries
    localparam logic [6:0] GP_FIRST  = 7'd3;
    localparam logic [6:0] GP_LAST0  = 7'd12;
    localparam logic [6:0] GP_LAST1  = 7'd10;
    localparam logic [6:0] GP_LAST2  = 7'd9;
    localparam logic [6:0] GP_LINK   = 7'd14;
    localparam logic [6:0] FP_FIRST  = 7'd6;
    localparam logic [6:0] FP_LAST   = 7'd31;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DECIDE,
        ST_EVICT,
        ST_OUT
    } state_t;

    function automatic logic in_pool(input logic [6:0] r, input logic cls,
                                     input logic [1:0] mode);
        logic hit;
        hit = 1'b0;
        if (cls)
        begin
            hit = (r >= FP_FIRST) && (r <= FP_LAST);
        end
        else
        begin
            case (mode)
                POOL_FULL:  hit = ((r >= GP_FIRST) && (r <= GP_LAST0)) || (r == GP_LINK);
                POOL_EIGHT: hit = (r >= GP_FIRST) && (r <= GP_LAST1);
                default:    hit = (r >= GP_FIRST) && (r <= GP_LAST2);
            endcase
        end
        return hit;
    endfunction

endpackage

// ----- sv/lsra_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_in_if
// Interval input channel: valid/ready with one live interval per beat.
// ----------------------------------------------------------------------------
interface lsra_in_if #(
    parameter int ID_BITS  = 12,
    parameter int POS_BITS = 16
);
    logic                valid;
    logic                ready;
    logic                restart;
    logic [ID_BITS-1:0]  interval_id;
    logic [POS_BITS-1:0] interval_start;
    logic [POS_BITS-1:0] interval_end;

    modport source (output valid, restart, interval_id, interval_start, interval_end,
                    input ready);
    modport sink   (input valid, restart, interval_id, interval_start, interval_end,
                    output ready);
endinterface

// ----- sv/lsra_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_out_if
// Result channel: valid/ready with one allocation decision per beat.
// ----------------------------------------------------------------------------
interface lsra_out_if #(
    parameter int ID_BITS = 12
);
    logic                            valid;
    logic                            ready;
    logic [ID_BITS-1:0]              result_id;
    logic                            in_register;
    logic [lsra_pkg::REGNO_BITS-1:0] register_number;
    logic                            evicted_valid;
    logic [ID_BITS-1:0]              evicted_id;

    modport source (output valid, result_id, in_register, register_number,
                    evicted_valid, evicted_id, input ready);
    modport sink   (input valid, result_id, in_register, register_number,
                    evicted_valid, evicted_id, output ready);
endinterface

// ----- sv/lsra_cfg_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_cfg_if
// Configuration write channel: register index and data per beat.
// ----------------------------------------------------------------------------
interface lsra_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [lsra_pkg::CFG_IDX_BITS-1:0]  index;
    logic [lsra_pkg::CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- sv/lsra_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_ram
// Simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lsra_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end
endmodule

// ----- sv/linear_scan_register_allocator.sv -----
`timescale 1ns / 1ps
// Sequence: the end-table sweep, a decide state, an evict state on an eviction, then the result.
// Intervals: a new interval is taken only when idle, after the last result is accepted;
//   the sweep reads one table entry per cycle through the single RAM read port.
// Reset: busy bits, configuration and control clear at once; end and owner RAMs
//   need no clearing since only busy entries are used.
// ----------------------------------------------------------------------------
// linear_scan_register_allocator
// Sweeps the end table per interval to expire, find a free register or the
// latest-ending one, then writes the table on an assignment and emits one result.
// ----------------------------------------------------------------------------
`include "linear_scan_register_allocator_macros.svh"

module linear_scan_register_allocator #(
    parameter int NUM_REGS = 32,
    parameter int ID_BITS  = 12,
    parameter int POS_BITS = 16
) (
    input logic         clk,
    input logic         rst_n,
    lsra_in_if.sink     in_ch,
    lsra_out_if.source  out_ch,
    lsra_cfg_if.sink    cfg
);
    localparam int IW = $clog2(NUM_REGS);
    localparam int CW = $clog2(NUM_REGS + 1);
    localparam logic [CW-1:0] SCAN_LAST = CW'(NUM_REGS);

    lsra_pkg::state_t state_reg, state_next;

    logic                register_class_reg;
    logic [1:0]          pool_mode_reg;
    logic                restart_reg;
    logic [ID_BITS-1:0]  id_reg;
    logic [POS_BITS-1:0] start_reg;
    logic [POS_BITS-1:0] end_reg;
    logic [CW-1:0]       cnt_reg;
    logic [NUM_REGS-1:0] busy_reg;
    logic                free_found_reg;
    logic [IW-1:0]       free_idx_reg;
    logic                max_found_reg;
    logic [IW-1:0]       max_idx_reg;
    logic [POS_BITS-1:0] max_end_reg;
    logic                res_got_reg;
    logic [lsra_pkg::REGNO_BITS-1:0] res_regno_reg;
    logic                res_ev_reg;
    logic [ID_BITS-1:0]  res_evid_reg;

    logic                end_wr_en;
    logic [IW-1:0]       wr_addr;
    logic [IW-1:0]       end_rd_addr;
    logic [POS_BITS-1:0] end_q;
    logic [ID_BITS-1:0]  owner_q;

    logic          in_fire;
    logic          cfg_fire;
    logic          do_evict;
    logic [IW-1:0] sidx;
    logic          s_busy;
    logic          s_exp;
    logic          s_still;
    logic          s_pool;

    assign in_fire  = in_ch.valid && in_ch.ready;
    assign cfg_fire = cfg.valid && cfg.ready;
    assign do_evict = max_found_reg && (max_end_reg > end_reg);

    // Compare stage of the sweep: entry read in the previous cycle
    assign sidx    = IW'(cnt_reg - CW'(1));
    assign s_busy  = busy_reg[sidx] && !restart_reg;
    assign s_exp   = s_busy && (end_q < start_reg);
    assign s_still = s_busy && !s_exp;
    assign s_pool  = lsra_pkg::in_pool(7'(sidx), register_class_reg, pool_mode_reg);

    // Table RAMs
    lsra_ram #(.WIDTH(POS_BITS), .DEPTH(NUM_REGS)) u_end_ram (
        .clk     (clk),
        .wr_en   (end_wr_en),
        .wr_addr (wr_addr),
        .wr_data (end_reg),
        .rd_addr (end_rd_addr),
        .rd_data (end_q)
    );

    lsra_ram #(.WIDTH(ID_BITS), .DEPTH(NUM_REGS)) u_owner_ram (
        .clk     (clk),
        .wr_en   (end_wr_en),
        .wr_addr (wr_addr),
        .wr_data (id_reg),
        .rd_addr (max_idx_reg),
        .rd_data (owner_q)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            lsra_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = lsra_pkg::ST_SCAN;
                end
            end
            lsra_pkg::ST_SCAN:
            begin
                if (cnt_reg == SCAN_LAST)
                begin
                    state_next = lsra_pkg::ST_DECIDE;
                end
            end
            lsra_pkg::ST_DECIDE:
            begin
                if (!free_found_reg && do_evict)
                begin
                    state_next = lsra_pkg::ST_EVICT;
                end
                else
                begin
                    state_next = lsra_pkg::ST_OUT;
                end
            end
            lsra_pkg::ST_EVICT:
            begin
                state_next = lsra_pkg::ST_OUT;
            end
            lsra_pkg::ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = lsra_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lsra_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs and RAM controls
    always_comb
    begin
        in_ch.ready = 1'b0;
        out_ch.valid = 1'b0;
        end_wr_en = 1'b0;
        wr_addr = max_idx_reg;
        end_rd_addr = cnt_reg[IW-1:0];
        case (state_reg)
            lsra_pkg::ST_IDLE:
            begin
                in_ch.ready = 1'b1;
            end
            lsra_pkg::ST_DECIDE:
            begin
                if (free_found_reg)
                begin
                    end_wr_en = 1'b1;
                    wr_addr = free_idx_reg;
                end
            end
            lsra_pkg::ST_EVICT:
            begin
                end_wr_en = 1'b1;
            end
            lsra_pkg::ST_OUT:
            begin
                out_ch.valid = 1'b1;
            end
            default:
            begin
                in_ch.ready = 1'b0;
            end
        endcase
    end

    assign cfg.ready = 1'b1;
    assign out_ch.result_id = id_reg;
    assign out_ch.in_register = res_got_reg;
    assign out_ch.register_number = res_regno_reg;
    assign out_ch.evicted_valid = res_ev_reg;
    assign out_ch.evicted_id = res_evid_reg;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= lsra_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            register_class_reg <= 1'b0;
            pool_mode_reg <= 2'd0;
        end
        else if (cfg_fire)
        begin
            if (cfg.index == lsra_pkg::CFG_REGISTER_CLASS)
            begin
                register_class_reg <= cfg.data[0];
            end
            else if (cfg.index == lsra_pkg::CFG_POOL_MODE)
            begin
                pool_mode_reg <= cfg.data[1:0];
            end
        end
    end

    // Busy bits: expire during the sweep, set on allocation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= '0;
        end
        else if ((state_reg == lsra_pkg::ST_SCAN) && (cnt_reg != '0))
        begin
            busy_reg[sidx] <= s_still;
        end
        else if ((state_reg == lsra_pkg::ST_DECIDE) && free_found_reg)
        begin
            busy_reg[free_idx_reg] <= 1'b1;
        end
    end

    // Sweep counter and search results
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            free_found_reg <= 1'b0;
            max_found_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            cnt_reg <= '0;
            free_found_reg <= 1'b0;
            max_found_reg <= 1'b0;
        end
        else if (state_reg == lsra_pkg::ST_SCAN)
        begin
            cnt_reg <= cnt_reg + CW'(1);
            if (cnt_reg != '0)
            begin
                // Ascending keeps the first free, float keeps the last (highest)
                if (s_pool && !s_still && (!free_found_reg || register_class_reg))
                begin
                    free_found_reg <= 1'b1;
                end
                // Strictly greater keeps the lowest register on ties
                if (s_pool && s_still && (!max_found_reg || (end_q > max_end_reg)))
                begin
                    max_found_reg <= 1'b1;
                end
            end
        end
    end

    // Search payload
    always_ff @(posedge clk)
    begin
        if ((state_reg == lsra_pkg::ST_SCAN) && (cnt_reg != '0))
        begin
            if (s_pool && !s_still && (!free_found_reg || register_class_reg))
            begin
                free_idx_reg <= sidx;
            end
            if (s_pool && s_still && (!max_found_reg || (end_q > max_end_reg)))
            begin
                max_idx_reg <= sidx;
                max_end_reg <= end_q;
            end
        end
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            restart_reg <= in_ch.restart;
            id_reg <= in_ch.interval_id;
            start_reg <= in_ch.interval_start;
            end_reg <= in_ch.interval_end;
        end
    end

    // Result register
    always_ff @(posedge clk)
    begin
        if (state_reg == lsra_pkg::ST_DECIDE)
        begin
            res_ev_reg <= 1'b0;
            res_evid_reg <= '0;
            if (free_found_reg)
            begin
                res_got_reg <= 1'b1;
                res_regno_reg <= lsra_pkg::REGNO_BITS'(free_idx_reg);
            end
            else
            begin
                res_got_reg <= 1'b0;
                res_regno_reg <= '0;
            end
        end
        else if (state_reg == lsra_pkg::ST_EVICT)
        begin
            res_got_reg <= 1'b1;
            res_regno_reg <= lsra_pkg::REGNO_BITS'(max_idx_reg);
            res_ev_reg <= 1'b1;
            res_evid_reg <= owner_q;
        end
    end

    `LSRA_ASSERT_NOW(a_no_overlap, clk, rst_n, out_ch.valid, !in_ch.ready,
                     "input taken while a result is pending")
    `LSRA_ASSERT_NEXT(a_accept_scans, clk, rst_n, in_fire,
                      (state_reg == lsra_pkg::ST_SCAN) && !in_ch.ready,
                      "accepted beat did not start a sweep")
    `LSRA_ASSERT_NOW(a_evict_assigned, clk, rst_n, out_ch.valid && out_ch.evicted_valid,
                     out_ch.in_register, "eviction without assignment")
    `LSRA_ASSERT_NOW(a_spill_clean, clk, rst_n, out_ch.valid && !out_ch.in_register,
                     (out_ch.register_number == '0) && !out_ch.evicted_valid,
                     "spilled result carries a register")
endmodule

// ----- bench/lsra_tb_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_tb_if
// Bench-side channel bundle: the block's own interfaces are used directly;
// this file only collects the shared beat record used by the checker.
// ----------------------------------------------------------------------------
package lsra_tb_pkg;

    // One allocation decision as seen on the result channel
    typedef struct packed {
        logic [11:0] result_id;
        logic        in_register;
        logic [4:0]  register_number;
        logic        evicted_valid;
        logic [11:0] evicted_id;
    } decision_t;

endpackage

// ----- bench/lsra_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsra_checker
// Watches interval, result and configuration beats, predicts every allocation
// decision from its own register table and compares results in order.
// ----------------------------------------------------------------------------
module lsra_checker (
    input  logic       clk,
    input  logic       rst_n,
    lsra_in_if.sink    in_ch,
    lsra_out_if.sink   out_ch,
    lsra_cfg_if.sink   cfg,
    output int         errors,
    output int         pending,
    output int         n_evict,
    output int         n_spill,
    output int         n_results
);
    logic        busy [32];
    logic [15:0] end_pos [32];
    logic [11:0] owner [32];
    logic        fp_class;
    logic [1:0]  mode;
    lsra_tb_pkg::decision_t expected_q[$];

    function automatic logic member(int r);
        if (fp_class)
        begin
            return r >= 6 && r <= 31;
        end
        if (mode == lsra_pkg::POOL_FULL)
        begin
            return (r >= 3 && r <= 12) || r == 14;
        end
        if (mode == lsra_pkg::POOL_EIGHT)
        begin
            return r >= 3 && r <= 10;
        end
        return r >= 3 && r <= 9;
    endfunction

    // Apply one interval to the table and return the decision
    function automatic lsra_tb_pkg::decision_t allocate(logic rs, logic [11:0] id,
                                                        logic [15:0] s, logic [15:0] e);
        lsra_tb_pkg::decision_t d;
        int pick;
        int r;
        d = '0;
        d.result_id = id;
        pick = -1;
        if (rs)
        begin
            for (int k = 0; k < 32; k++) busy[k] = 1'b0;
        end
        for (int k = 0; k < 32; k++)
        begin
            if (busy[k] && end_pos[k] < s) busy[k] = 1'b0;
        end
        for (int k = 0; k < 32 && pick < 0; k++)
        begin
            r = fp_class ? 31 - k : k;
            if (member(r) && !busy[r]) pick = r;
        end
        if (pick >= 0)
        begin
            busy[pick] = 1'b1;
            end_pos[pick] = e;
            owner[pick] = id;
            d.in_register = 1'b1;
            d.register_number = pick[4:0];
        end
        else
        begin
            for (int k = 0; k < 32; k++)
            begin
                if (member(k) && busy[k] && (pick < 0 || end_pos[k] > end_pos[pick]))
                    pick = k;
            end
            if (pick >= 0 && end_pos[pick] > e)
            begin
                d.evicted_valid = 1'b1;
                d.evicted_id = owner[pick];
                end_pos[pick] = e;
                owner[pick] = id;
                d.in_register = 1'b1;
                d.register_number = pick[4:0];
            end
        end
        return d;
    endfunction

    assign pending = expected_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        lsra_tb_pkg::decision_t want;
        lsra_tb_pkg::decision_t got;
        if (!rst_n)
        begin
            for (int k = 0; k < 32; k++) busy[k] = 1'b0;
            fp_class = 1'b0;
            mode = 2'd0;
            expected_q.delete();
            errors <= 0;
            n_evict <= 0;
            n_spill <= 0;
            n_results <= 0;
        end
        else
        begin
            // Track configuration writes
            if (cfg.valid && cfg.ready)
            begin
                if (cfg.index == lsra_pkg::CFG_REGISTER_CLASS) fp_class = cfg.data[0];
                else if (cfg.index == lsra_pkg::CFG_POOL_MODE) mode = cfg.data;
            end
            // Compare a result beat with the oldest prediction
            if (out_ch.valid && out_ch.ready)
            begin
                got = '{out_ch.result_id, out_ch.in_register, out_ch.register_number,
                        out_ch.evicted_valid, out_ch.evicted_id};
                n_results <= n_results + 1;
                if (expected_q.size() == 0)
                begin
                    if (errors < 10) $display("unexpected result beat id=%0d", got.result_id);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_q.pop_front();
                    if (want.evicted_valid) n_evict <= n_evict + 1;
                    if (!want.in_register) n_spill <= n_spill + 1;
                    if (got !== want)
                    begin
                        if (errors < 10)
                        begin
                            $display("mismatch exp id=%0d reg=%0b/%0d ev=%0b/%0d",
                                     want.result_id, want.in_register, want.register_number,
                                     want.evicted_valid, want.evicted_id);
                            $display("         got id=%0d reg=%0b/%0d ev=%0b/%0d",
                                     got.result_id, got.in_register, got.register_number,
                                     got.evicted_valid, got.evicted_id);
                        end
                        errors <= errors + 1;
                    end
                end
            end
            // Predict on each accepted interval
            if (in_ch.valid && in_ch.ready)
                expected_q.push_back(allocate(in_ch.restart, in_ch.interval_id,
                                              in_ch.interval_start, in_ch.interval_end));
        end
    end
endmodule

// ----- bench/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives live intervals and pool settings into the allocator with random
// gaps and stalls; the checker predicts and compares every decision.
// ----------------------------------------------------------------------------
module tb_top;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   errors, pending, n_evict, n_spill, n_results;
    logic calm;
    logic hold_off;
    int   n_sent;
    logic [15:0] cursor;

    lsra_in_if  in_ch ();
    lsra_out_if out_ch ();
    lsra_cfg_if cfg ();

    linear_scan_register_allocator u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch),
        .cfg    (cfg)
    );

    lsra_checker u_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg       (cfg),
        .errors    (errors),
        .pending   (pending),
        .n_evict   (n_evict),
        .n_spill   (n_spill),
        .n_results (n_results)
    );

    always #2 clk = ~clk;

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.restart = 1'b0;
        in_ch.interval_id = '0;
        in_ch.interval_start = '0;
        in_ch.interval_end = '0;
        out_ch.ready = 1'b0;
        cfg.valid = 1'b0;
        cfg.index = lsra_pkg::CFG_REGISTER_CLASS;
        cfg.data = '0;
        calm = 1'b0;
        hold_off = 1'b0;
    end

    // Receiver: random stalls, plus a long hold-off when asked
    always @(posedge clk)
    begin
        out_ch.ready <= !hold_off && (calm || $urandom_range(99) >= 37);
    end

    // Send one interval beat, idling for a random gap first; valid stays up
    // after the beat until a later gap or an input drop clears it
    task automatic send(input logic rs, input logic [11:0] id,
                        input logic [15:0] s, input logic [15:0] e);
        while (!calm && $urandom_range(99) < 37)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.restart <= rs;
        in_ch.interval_id <= id;
        in_ch.interval_start <= s;
        in_ch.interval_end <= e;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        n_sent++;
    endtask

    // Drop the input, wait out all results, then write one register
    task automatic set_reg(input logic [lsra_pkg::CFG_IDX_BITS-1:0] idx,
                           input logic [lsra_pkg::CFG_DATA_BITS-1:0] val);
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        cfg.valid <= 1'b0;
    endtask

    // Random function: starts mostly step up with occasional random jumps, lives mostly short
    task automatic random_function(input int count);
        logic [15:0] e;
        logic [15:0] s;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(9) == 0) cursor = 16'($urandom);
            else cursor = cursor + 16'($urandom_range(3));
            s = cursor;
            case ($urandom_range(9))
                0: e = 16'($urandom);
                1: e = s - 16'($urandom_range(4));
                default: e = s + 16'($urandom_range(40));
            endcase
            send(i == 0 || $urandom_range(49) == 0, 12'($urandom), s, e);
        end
    endtask

    initial
    begin
        n_sent = 0;
        cursor = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: fill the full general pool, evict, spill, expire
        for (int i = 0; i < 11; i++) send(i == 0, 12'(i), 16'd10, 16'd100 + 16'(i));
        send(1'b0, 12'hfff, 16'd10, 16'd50);
        send(1'b0, 12'd20, 16'd10, 16'd110);
        send(1'b0, 12'd21, 16'd10, 16'd50);
        send(1'b0, 12'd22, 16'hffff, 16'hffff);
        send(1'b0, 12'd23, 16'hffff, 16'd0);
        send(1'b1, 12'd0, 16'd0, 16'd0);
        send(1'b0, 12'd24, 16'd5, 16'd2);
        send(1'b0, 12'hfff, 16'd3, 16'hffff);

        // Sweep settings; mode three included
        for (int m = 0; m < 4; m++)
        begin
            set_reg(lsra_pkg::CFG_REGISTER_CLASS, 2'd0);
            set_reg(lsra_pkg::CFG_POOL_MODE, 2'(m));
            random_function(110);
        end
        set_reg(lsra_pkg::CFG_REGISTER_CLASS, 2'd1);
        random_function(150);

        // Pool change without restart: stale registers stay busy
        set_reg(lsra_pkg::CFG_REGISTER_CLASS, 2'd0);
        random_function(120);
        set_reg(lsra_pkg::CFG_POOL_MODE, 2'd2);
        send(1'b0, 12'd7, cursor, cursor + 16'd5);
        random_function(100);

        // Long receiver hold-off while intervals keep coming
        fork
            begin
                hold_off = 1'b1;
                repeat (400) @(posedge clk);
                hold_off = 1'b0;
            end
            random_function(20);
        join

        // Stretch with no idling
        calm = 1'b1;
        random_function(120);
        calm = 1'b0;
        set_reg(lsra_pkg::CFG_REGISTER_CLASS, 2'd1);
        random_function(160);

        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (60) @(posedge clk);
        $display("Sent %0d intervals, %0d results: %0d evictions, %0d spills.",
                 n_sent, n_results, n_evict, n_spill);
        $display("Covered both register classes and all four pool modes.");
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("FAIL");
        $finish;
    end
endmodule

// ----- filelist.f -----
+incdir+sv
sv/lsra_pkg.sv
sv/lsra_in_if.sv
sv/lsra_out_if.sv
sv/lsra_cfg_if.sv
sv/lsra_ram.sv
sv/linear_scan_register_allocator.sv
bench/lsra_tb_if.sv
bench/lsra_checker.sv
bench/tb_top.sv
